// ----- hw/rtl/ejkm_pkg.sv -----
package ejkm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_LOADED    = 3'd0,
        ST_FULL_DROP = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CLEARED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } state_t;

    localparam int IDX_OUT_BITS = 10;
    localparam int VAL_BITS     = 32;
    localparam int IN_KEY_BITS  = 32;
    localparam int IN_DATA_BITS = 72;
    localparam int OUT_DATA_BITS = 48;

endpackage

// ----- hw/rtl/equi_join_key_match_top.sv -----
// Join probe engine. A load item (tuser = 0) appends a row {link_key, field_value, row_valid}
// to the source table; a full table drops the row and reports it. A probe item (tuser = 1)
// scans the stored rows from index 0 and returns the first non-null row whose key matches
// on its low KEY_BITS bits (all 32 when KEY_BITS is 32 or more), with its value, or zeros
// and a set sticky miss flag on a miss. A clear item (tuser = 2) reports the miss flag,
// then empties the table and clears the flag; tuser = 3 is taken and gives no result.
// One item is worked on at a time. The table memory has a single read port, read one row per
// cycle during the scan. A new item is taken as soon as the result has moved into the output
// register, even while that result still waits for m_tready. The table needs no clearing after
// reset.
module equi_join_key_match_top #(
    parameter int SRC_ROWS = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // link_key[31:0], field_value[63:32], row_valid[64], zero fill [71:65]
    input  logic [ejkm_pkg::IN_DATA_BITS-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    // last_probe
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], match_index[10:1], joined_value[42:11], any_miss[43], zero fill [47:44]
    output logic [ejkm_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser,
    // batch_done
    output logic        m_tlast
);

    localparam int KB    = (KEY_BITS < ejkm_pkg::IN_KEY_BITS) ? KEY_BITS
                                                               : ejkm_pkg::IN_KEY_BITS;
    localparam int AW    = (SRC_ROWS > 1) ? $clog2(SRC_ROWS) : 1;
    localparam int CNT_W = $clog2(SRC_ROWS + 1);
    localparam int VB    = ejkm_pkg::VAL_BITS;
    localparam int IB    = ejkm_pkg::IDX_OUT_BITS;
    localparam int MW    = 1 + VB + KB;

    ejkm_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic             miss_seen_reg, miss_seen_next;
    logic [KB-1:0]    probe_key_reg, probe_key_next;
    logic             probe_last_reg, probe_last_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;

    ejkm_pkg::status_t res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic [IB-1:0]    res_idx_reg, res_idx_next;
    logic [VB-1:0]    res_val_reg, res_val_next;
    logic             res_miss_reg, res_miss_next;
    logic             res_last_reg, res_last_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [ejkm_pkg::OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]       m_tuser_reg, m_tuser_next;
    logic             m_tlast_reg, m_tlast_next;

    // table memory: {valid, value, key}
    logic [MW-1:0]    tbl_mem [SRC_ROWS];
    logic [MW-1:0]    rd_data_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [MW-1:0]    wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    logic             accept;
    logic             table_full;
    logic             hit;
    logic             scan_end;
    logic             out_free;
    logic [AW+IB-1:0] cmp_idx_ext;
    logic [CNT_W-1:0] last_row;

    logic [KB-1:0]    in_key;
    logic [VB-1:0]    in_val;
    logic             in_valid;

    assign in_key   = s_tdata[KB-1:0];
    assign in_val   = s_tdata[2*VB-1:VB];
    assign in_valid = s_tdata[2*VB];

    assign s_tready   = (state_reg == ejkm_pkg::S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign table_full = (row_count_reg == CNT_W'(SRC_ROWS));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_row   = row_count_reg - 1'b1;

    assign rd_en   = (state_reg == ejkm_pkg::S_SCAN) && (issue_idx_reg < row_count_reg);
    assign rd_addr = issue_idx_reg[AW-1:0];

    assign hit = cmp_vld_reg && rd_data_reg[MW-1] && (rd_data_reg[KB-1:0] == probe_key_reg);
    assign scan_end = cmp_vld_reg && (cmp_idx_reg == last_row);
    assign cmp_idx_ext = {{IB{1'b0}}, cmp_idx_reg[AW-1:0]};

    assign wr_addr = row_count_reg[AW-1:0];
    assign wr_data = {in_valid, in_val, in_key};

    always_comb
    begin
        state_next      = state_reg;
        row_count_next  = row_count_reg;
        miss_seen_next  = miss_seen_reg;
        probe_key_next  = probe_key_reg;
        probe_last_next = probe_last_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_idx_next    = issue_idx_reg;
        cmp_vld_next    = rd_en;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        res_val_next    = res_val_reg;
        res_miss_next   = res_miss_reg;
        res_last_next   = res_last_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        wr_en           = 1'b0;

        case (state_reg)
            ejkm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    res_val_next   = '0;
                    res_last_next  = 1'b0;
                    res_miss_next  = miss_seen_reg;
                    case (ejkm_pkg::opcode_t'(s_tuser))
                        ejkm_pkg::OP_LOAD:
                        begin
                            state_next = ejkm_pkg::S_POST;
                            if (table_full)
                            begin
                                res_status_next = ejkm_pkg::ST_FULL_DROP;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                row_count_next  = row_count_reg + 1'b1;
                                res_status_next = ejkm_pkg::ST_LOADED;
                            end
                        end
                        ejkm_pkg::OP_PROBE:
                        begin
                            probe_key_next  = in_key;
                            probe_last_next = s_tlast;
                            res_last_next   = s_tlast;
                            issue_idx_next  = '0;
                            if (row_count_reg == '0)
                            begin
                                res_status_next = ejkm_pkg::ST_NOT_FOUND;
                                res_miss_next   = 1'b1;
                                miss_seen_next  = 1'b1;
                                state_next      = ejkm_pkg::S_POST;
                            end
                            else
                            begin
                                state_next = ejkm_pkg::S_SCAN;
                            end
                        end
                        ejkm_pkg::OP_CLEAR:
                        begin
                            res_status_next = ejkm_pkg::ST_CLEARED;
                            row_count_next  = '0;
                            miss_seen_next  = 1'b0;
                            state_next      = ejkm_pkg::S_POST;
                        end
                        default:
                        begin
                            // unused opcode: drop the item
                            state_next = ejkm_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ejkm_pkg::S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                res_last_next = probe_last_reg;
                if (hit)
                begin
                    res_status_next = ejkm_pkg::ST_FOUND;
                    res_found_next  = 1'b1;
                    res_idx_next    = cmp_idx_ext[IB-1:0];
                    res_val_next    = rd_data_reg[KB+VB-1:KB];
                    res_miss_next   = miss_seen_reg;
                    state_next      = ejkm_pkg::S_POST;
                end
                else if (scan_end)
                begin
                    res_status_next = ejkm_pkg::ST_NOT_FOUND;
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    res_val_next    = '0;
                    res_miss_next   = 1'b1;
                    miss_seen_next  = 1'b1;
                    state_next      = ejkm_pkg::S_POST;
                end
            end
            ejkm_pkg::S_POST:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, res_miss_reg, res_val_reg, res_idx_reg,
                                     res_found_reg};
                    m_tuser_next  = res_status_reg;
                    m_tlast_next  = res_last_reg;
                    state_next    = ejkm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ejkm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ejkm_pkg::S_IDLE;
            row_count_reg <= '0;
            miss_seen_reg <= 1'b0;
            issue_idx_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            miss_seen_reg <= miss_seen_next;
            issue_idx_reg <= issue_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_key_reg  <= probe_key_next;
        probe_last_reg <= probe_last_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_idx_reg    <= res_idx_next;
        res_val_reg    <= res_val_next;
        res_miss_reg   <= res_miss_next;
        res_last_reg   <= res_last_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= CNT_W'(SRC_ROWS))
        else $error("row count beyond table depth");

    a_cmp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ejkm_pkg::S_SCAN) && cmp_vld_reg |-> cmp_idx_reg < row_count_reg)
        else $error("compare on a row past the fill count");

    a_post_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ejkm_pkg::S_POST) && out_free
        |=> m_tvalid_reg && (state_reg == ejkm_pkg::S_IDLE))
        else $error("pending result not moved to output");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[0] |-> m_tuser_reg == ejkm_pkg::ST_FOUND)
        else $error("found flag without found status");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ejkm_pkg::S_SCAN) |=> $stable(row_count_reg))
        else $error("table changed during scan");

endmodule

// ----- bench/equi_join_key_match_top_tb.sv -----
`timescale 1ns / 100ps

module equi_join_key_match_top_tb;

    localparam int ROWS = 1024;
    localparam int KBITS = 32;
    localparam logic [31:0] KEY_MASK = (KBITS >= 32) ? 32'hFFFF_FFFF
                                                     : ((32'd1 << KBITS) - 32'd1);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FILL_KEY = 32'h4000_0000;
    localparam int FILL_ROWS = 256;
    localparam int HOLD_CYCLES = 400;
    // slowest item is a full-table scan plus receiver stalls
    localparam int STALL_LIMIT = 6000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        logic        rv;
        logic        last;
    } src_item_t;

    typedef struct packed {
        logic [2:0]  st;
        logic        found;
        logic [9:0]  idx;
        logic [31:0] val;
        logic        miss;
        logic        done;
    } join_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ejkm_pkg::IN_DATA_BITS-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ejkm_pkg::OUT_DATA_BITS-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    equi_join_key_match_top #(
        .SRC_ROWS (ROWS),
        .KEY_BITS (KBITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the source table
    logic [31:0] tbl_key [ROWS];
    logic [31:0] tbl_val [ROWS];
    logic        tbl_ok  [ROWS];
    int          row_cnt = 0;
    logic        miss_flag = 1'b0;

    src_item_t    items_to_send [$];
    join_result_t join_results_due [$];
    logic [31:0]  loaded_keys [$];
    src_item_t    on_bus;
    join_result_t due_res;
    join_result_t got_res;
    join_result_t want_res;

    int send_pct = 0;
    int recv_pct = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int stall_cnt = 0;

    int n_in = 0;
    int n_out = 0;
    int n_hit = 0;
    int n_miss = 0;
    int n_drop = 0;
    int n_clear = 0;
    int n_err = 0;

    function automatic bit join_lookup(input src_item_t it, output join_result_t r);
        int j;
        r = '0;
        case (it.op)
            ejkm_pkg::OP_LOAD:
            begin
                if (row_cnt >= ROWS)
                begin
                    r.st = ejkm_pkg::ST_FULL_DROP;
                end
                else
                begin
                    tbl_key[row_cnt] = it.key;
                    tbl_val[row_cnt] = it.val;
                    tbl_ok[row_cnt] = it.rv;
                    row_cnt++;
                    r.st = ejkm_pkg::ST_LOADED;
                end
                r.miss = miss_flag;
                return 1'b1;
            end
            ejkm_pkg::OP_PROBE:
            begin
                r.done = it.last;
                for (j = 0; j < row_cnt; j++)
                begin
                    if (tbl_ok[j] && ((tbl_key[j] & KEY_MASK) == (it.key & KEY_MASK)))
                    begin
                        r.st = ejkm_pkg::ST_FOUND;
                        r.found = 1'b1;
                        r.idx = j[9:0];
                        r.val = tbl_val[j];
                        r.miss = miss_flag;
                        return 1'b1;
                    end
                end
                miss_flag = 1'b1;
                r.st = ejkm_pkg::ST_NOT_FOUND;
                r.miss = 1'b1;
                return 1'b1;
            end
            ejkm_pkg::OP_CLEAR:
            begin
                r.st = ejkm_pkg::ST_CLEARED;
                r.miss = miss_flag;
                row_cnt = 0;
                miss_flag = 1'b0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                n_in++;
                if (join_lookup(on_bus, due_res))
                    join_results_due.push_back(due_res);
            end
            if (!s_tvalid || s_tready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_pct)
                begin
                    on_bus = items_to_send.pop_front();
                    s_tdata <= {7'b0, on_bus.rv, on_bus.val, on_bus.key};
                    s_tuser <= on_bus.op;
                    s_tlast <= on_bus.last;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random backpressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = {m_tuser, m_tdata[0], m_tdata[10:1], m_tdata[42:11], m_tdata[43],
                       m_tlast};
            n_out++;
            case (got_res.st)
                ejkm_pkg::ST_FOUND:     n_hit++;
                ejkm_pkg::ST_NOT_FOUND: n_miss++;
                ejkm_pkg::ST_FULL_DROP: n_drop++;
                ejkm_pkg::ST_CLEARED:   n_clear++;
                default:                ;
            endcase
            if (join_results_due.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected result st=%0d found=%0d idx=%0d val=%h miss=%0d done=%0d",
                         $time, got_res.st, got_res.found, got_res.idx, got_res.val,
                         got_res.miss, got_res.done);
            end
            else
            begin
                want_res = join_results_due.pop_front();
                if (got_res !== want_res)
                begin
                    n_err++;
                    $display("%0t: mismatch expected st=%0d found=%0d idx=%0d val=%h miss=%0d done=%0d",
                             $time, want_res.st, want_res.found, want_res.idx, want_res.val,
                             want_res.miss, want_res.done);
                    $display("%0t:          actual   st=%0d found=%0d idx=%0d val=%h miss=%0d done=%0d",
                             $time, got_res.st, got_res.found, got_res.idx, got_res.val,
                             got_res.miss, got_res.done);
                end
            end
        end
    end

    // watchdog: cycles without any handshake while work is outstanding
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else if (items_to_send.size() != 0 || s_tvalid || join_results_due.size() != 0)
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("equi_join_key_match_top verification failed");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [31:0] key,
                              input logic [31:0] val, input logic rv, input logic last);
        src_item_t it;
        it.op = op;
        it.key = key;
        it.val = val;
        it.rv = rv;
        it.last = last;
        items_to_send.push_back(it);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0:       return INT_MIN;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0;
            3:       return INT_MAX;
            4, 5, 6: return $urandom_range(15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(7))
            0:       return INT_MIN;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0;
            3:       return INT_MAX;
            default: return $urandom();
        endcase
    endfunction

    // mostly load/probe sessions over known keys, some clears and unused opcodes
    task automatic gen_random(input int count);
        int i;
        int r;
        logic [31:0] k;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                queue_item(OP_UNUSED, $urandom(), $urandom(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
            else if (r < 7)
            begin
                queue_item(ejkm_pkg::OP_CLEAR, $urandom(), $urandom(),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
                loaded_keys.delete();
            end
            else if (r < 42)
            begin
                k = pick_key();
                queue_item(ejkm_pkg::OP_LOAD, k, pick_val(), $urandom_range(4) != 0,
                           1'($urandom_range(1)));
                loaded_keys.push_back(k);
            end
            else
            begin
                if (loaded_keys.size() != 0 && $urandom_range(3) != 0)
                    k = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
                else
                    k = pick_key();
                queue_item(ejkm_pkg::OP_PROBE, k, $urandom(), 1'($urandom_range(1)),
                           $urandom_range(3) == 0);
            end
        end
    endtask

    // build a deep table and probe far rows
    task automatic fill_table();
        int i;
        queue_item(ejkm_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);
        for (i = 0; i < FILL_ROWS; i++)
            queue_item(ejkm_pkg::OP_LOAD, FILL_KEY | i, $urandom(), (i % 7) != 3,
                       1'($urandom_range(1)));
        queue_item(ejkm_pkg::OP_LOAD, INT_MIN, INT_MAX, 1'b1, 1'b0);
        queue_item(ejkm_pkg::OP_LOAD, 32'hFFFF_FFFF, INT_MIN, 1'b0, 1'b1);
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY | (FILL_ROWS - 2), 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY, 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY | 200, 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY | 128, 32'h0, 1'b0, 1'b1);
        // null row: full-table miss
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY | 3, 32'h0, 1'b0, 1'b1);
        queue_item(ejkm_pkg::OP_PROBE, INT_MAX, 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_LOAD, 32'h0, 32'h0, 1'b1, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY | 170, 32'h0, 1'b0, 1'b1);
        queue_item(ejkm_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, FILL_KEY, 32'h0, 1'b0, 1'b1);
        queue_item(ejkm_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);
        loaded_keys.delete();
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || s_tvalid || join_results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_pct = 27;
        recv_pct = 61;
        // probe on an empty table, then clear reports the miss
        queue_item(ejkm_pkg::OP_PROBE, 32'h0, INT_MAX, 1'b1, 1'b1);
        queue_item(ejkm_pkg::OP_CLEAR, INT_MAX, INT_MIN, 1'b1, 1'b1);
        queue_item(ejkm_pkg::OP_LOAD, INT_MIN, INT_MAX, 1'b1, 1'b1);
        queue_item(ejkm_pkg::OP_LOAD, 32'hFFFF_FFFF, INT_MIN, 1'b1, 1'b0);
        queue_item(ejkm_pkg::OP_LOAD, 32'd5, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_LOAD, 32'd5, 32'd123, 1'b1, 1'b0);
        queue_item(ejkm_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'd77, 1'b1, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, INT_MIN, 32'h0, 1'b0, 1'b0);
        // duplicate key: lowest row wins
        queue_item(ejkm_pkg::OP_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // null row skipped
        queue_item(ejkm_pkg::OP_PROBE, 32'd5, 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_PROBE, INT_MAX, 32'h0, 1'b0, 1'b1);
        queue_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_item(ejkm_pkg::OP_PROBE, 32'h0, 32'h0, 1'b0, 1'b1);
        queue_item(ejkm_pkg::OP_LOAD, 32'h0, 32'h0, 1'b1, 1'b1);
        queue_item(ejkm_pkg::OP_PROBE, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_item(OP_UNUSED, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_item(ejkm_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b0, 1'b0);
        // table emptied by the clear
        queue_item(ejkm_pkg::OP_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
        queue_item(ejkm_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        gen_random(100);
        hold_go = 1'b1;
        wait_drained();

        send_pct = 61;
        recv_pct = 27;
        gen_random(100);
        wait_drained();

        send_pct = 0;
        recv_pct = 0;
        gen_random(100);
        fill_table();
        wait_drained();

        // let any late result from an unused opcode show up
        repeat (ROWS + 16) @(negedge clk);

        $display("Ran %0d items through three idle mixes and one long output stall;",
                 n_in);
        $display("checked %0d results: %0d hits, %0d misses, %0d full-table drops, %0d clears",
                 n_out, n_hit, n_miss, n_drop, n_clear);
        if (n_err == 0)
        begin
            $display("equi_join_key_match_top verification clean");
        end
        else
        begin
            $display("%0d errors", n_err);
            $display("equi_join_key_match_top verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ejkm_pkg.sv
hw/rtl/equi_join_key_match_top.sv
bench/equi_join_key_match_top_tb.sv
